[design/sha_pkg.sv]
// shared constants, types and functions of the sha-256 stream hasher
package sha_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	// byte source selected for a buffer write
	localparam logic [1:0] WSEL_DATA = 2'd0;
	localparam logic [1:0] WSEL_PAD = 2'd1;
	localparam logic [1:0] WSEL_ZERO = 2'd2;
	localparam logic [1:0] WSEL_LEN = 2'd3;

	typedef struct packed {
		logic       buf_wr;     // write one byte to the block buffer
		logic [1:0] wsel;       // byte source
		logic       add_len;    // count the data byte into the length
		logic       comp_start; // start a block compression
		logic       restart;    // back to initial hash, length and fill
		logic       out_load;   // load digest word into the output register
		logic [2:0] out_idx;    // digest word to load
	} sha_cmd_t;

	typedef struct packed {
		logic [5:0] fill;      // bytes in the current block
		logic       comp_busy; // compression under way
	} sha_sts_t;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		ror32 = (v >> n) | (v << (32 - n));
	endfunction

endpackage

[design/sha_if.sv]
// valid/ready channel carrying a payload beat
interface sha_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/sha256_stream_hasher.sv]
// top level of the sha-256 stream hasher
//  channel  | dir | payload
//  in_ch    | in  | data_byte[7:0], has_byte, end_of_message
//  out_ch   | out | digest_word[31:0], word_number[2:0], last_word
// a byte beat is taken while in_ch is ready; a full block then holds input
// while the single round unit runs one round per cycle.
// an end mark adds the padding bytes plus one or two compressions,
// then eight digest beats, one per cycle when out_ch is ready.
// arst_n returns the hash, length and fill count to their initial values.
// a stalled output holds the digest register; input is not taken meanwhile.
module sha256_stream_hasher
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha_if.sink   in_ch,
	sha_if.source out_ch
);
	sha_cmd_t    cmd;
	sha_sts_t    sts;
	logic [31:0] dword;
	logic [31:0] dword_q;
	logic        oload;
	logic [2:0]  wnum;
	logic        lw;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.has_byte(in_ch.payload.has_byte),
		.end_of_message(in_ch.payload.end_of_message),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.word_number(wnum), .last_word(lw), .out_load(oload),
		.cmd(cmd), .sts(sts)
	);

	sha_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.data_byte(in_ch.payload.data_byte), .sts(sts), .digest_word(dword)
	);

	// digest output register
	always_ff @(posedge clk) begin
		if (oload)
			dword_q <= dword;
	end

	assign out_ch.payload.digest_word = dword_q;
	assign out_ch.payload.word_number = wnum;
	assign out_ch.payload.last_word = lw;

	// no input is taken while a digest is pending
	a_no_in_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
	// last flag marks word seven
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.payload.last_word |-> out_ch.payload.word_number == 3'd7)
		else $error("last_word misplaced");
	// compression never starts while one runs
	a_comp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.comp_start |-> !sts.comp_busy) else $error("compression overlap");
endmodule

[design/sha_dp.sv]
// datapath: block buffer, message schedule, round unit, hash state and length
module sha_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::sha_cmd_t   cmd,
	input  logic [7:0]          data_byte,
	output sha_pkg::sha_sts_t   sts,
	output logic [31:0]         digest_word
);
	import sha_pkg::*;

	logic [31:0] blk_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        load_q;
	logic [7:0]  wbyte;
	logic [31:0] wt, t1, t2, s0, s1, wnew, pe, pa;

	assign sts.fill = fill_q;
	assign sts.comp_busy = busy_q | load_q;
	assign digest_word = h_q[cmd.out_idx];

	// byte to write into the buffer
	always_comb begin
		case (cmd.wsel)
			WSEL_DATA: wbyte = data_byte;
			WSEL_PAD:  wbyte = PAD_BYTE;
			WSEL_ZERO: wbyte = 8'h00;
			WSEL_LEN:  wbyte = len_q[8 * (7 - fill_q[2:0]) +: 8];
			default:   wbyte = 8'h00;
		endcase
	end

	// block buffer, sixteen big-endian words, first byte in the top lane
	always_ff @(posedge clk) begin
		if (cmd.buf_wr)
			blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wbyte;
	end

	// fill count and bit length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q <= '0;
		end else if (cmd.restart) begin
			fill_q <= '0;
			len_q <= '0;
		end else begin
			if (cmd.buf_wr)
				fill_q <= fill_q + 6'd1;
			if (cmd.add_len)
				len_q <= len_q + 64'd8;
		end
	end

	// round logic
	always_comb begin
		wt = w_q[0];
		pe = v_q[4];
		pa = v_q[0];
		t1 = v_q[7] + (ror32(pe, 6) ^ ror32(pe, 11) ^ ror32(pe, 25)) +
			((pe & v_q[5]) ^ (~pe & v_q[6])) + ROUND_K[rnd_q] + wt;
		t2 = (ror32(pa, 2) ^ ror32(pa, 13) ^ ror32(pa, 22)) +
			((pa & v_q[1]) ^ (pa & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
	end

	// compression control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			load_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			load_q <= cmd.comp_start;
			if (load_q) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63)
					busy_q <= 1'b0;
			end
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (load_q) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk_q[i];
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= wnew;
		end
	end

	// hash state: initial value on reset or restart, updated at round 63
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				h_q[i] <= START_H[i];
		end else if (cmd.restart) begin
			for (int i = 0; i < 8; i++)
				h_q[i] <= START_H[i];
		end else if (busy_q && rnd_q == 6'd63) begin
			h_q[0] <= h_q[0] + t1 + t2;
			h_q[1] <= h_q[1] + v_q[0];
			h_q[2] <= h_q[2] + v_q[1];
			h_q[3] <= h_q[3] + v_q[2];
			h_q[4] <= h_q[4] + v_q[3] + t1;
			h_q[5] <= h_q[5] + v_q[4];
			h_q[6] <= h_q[6] + v_q[5];
			h_q[7] <= h_q[7] + v_q[6];
		end
	end
endmodule

[design/sha_ctrl.sv]
// controller: input acceptance, padding sequence and digest output
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              has_byte,
	input  logic              end_of_message,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        word_number,
	output logic              last_word,
	output logic              out_load,
	output sha_pkg::sha_cmd_t cmd,
	input  sha_pkg::sha_sts_t sts
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD = 3'd1; // write 0x80
	localparam logic [2:0] ST_ZERO = 3'd2; // zero fill
	localparam logic [2:0] ST_LEN = 3'd3; // length bytes
	localparam logic [2:0] ST_WAIT = 3'd4; // final compression
	localparam logic [2:0] ST_OUT = 3'd5; // digest words

	logic [2:0] state_q, state_d;
	logic       eom_q, eom_d;  // end mark pending behind a compression
	logic       ovalid_q;
	logic [2:0] widx_q, widx_d;
	logic       acc, busy;

	assign busy = sts.comp_busy;
	assign in_ready = (state_q == ST_IDLE) && !busy && !eom_q;
	assign acc = in_valid && in_ready;
	assign out_valid = ovalid_q;
	assign last_word = (word_number == 3'd7);
	assign out_load = cmd.out_load;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		eom_d = eom_q;
		widx_d = widx_q;
		case (state_q)
			ST_IDLE: begin
				if (eom_q && !busy) begin
					eom_d = 1'b0;
					state_d = ST_PAD;
				end else if (acc) begin
					if (has_byte) begin
						cmd.buf_wr = 1'b1;
						cmd.wsel = WSEL_DATA;
						cmd.add_len = 1'b1;
						if (sts.fill == 6'd63)
							cmd.comp_start = 1'b1;
					end
					if (end_of_message) begin
						if (has_byte && sts.fill == 6'd63)
							eom_d = 1'b1;
						else
							state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.buf_wr = 1'b1;
				cmd.wsel = WSEL_PAD;
				if (sts.fill == 6'd63) begin
					cmd.comp_start = 1'b1;
					state_d = ST_ZERO;
				end else if (sts.fill == LEN_POS - 6'd1)
					state_d = ST_LEN;
				else
					state_d = ST_ZERO;
			end
			ST_ZERO: begin
				if (!busy) begin
					cmd.buf_wr = 1'b1;
					cmd.wsel = WSEL_ZERO;
					if (sts.fill == 6'd63)
						cmd.comp_start = 1'b1;
					else if (sts.fill == LEN_POS - 6'd1)
						state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.buf_wr = 1'b1;
				cmd.wsel = WSEL_LEN;
				if (sts.fill == 6'd63) begin
					cmd.comp_start = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!busy) begin
					cmd.out_load = 1'b1;
					cmd.out_idx = 3'd0;
					widx_d = 3'd1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!ovalid_q || out_ready) begin
					cmd.out_idx = widx_q;
					if (widx_q == 3'd0 && ovalid_q) begin
						cmd.restart = 1'b1;
						state_d = ST_IDLE;
					end else if (widx_q != 3'd0) begin
						cmd.out_load = 1'b1;
						widx_d = widx_q + 3'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eom_q <= 1'b0;
			widx_q <= '0;
			ovalid_q <= 1'b0;
			word_number <= '0;
		end else begin
			state_q <= state_d;
			eom_q <= eom_d;
			widx_q <= widx_d;
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
				word_number <= cmd.out_idx;
			end else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end
endmodule
